[hdl/sol_pkg.sv]
package sol_pkg;

  // Range scaling of the channel: FULL_SCALE range units stand for 100 percent.
  localparam int FULL_SCALE       = 10000;
  localparam int UPDATE_PERIOD_MS = 5;

  // Fixed divisors of the percent, speed and tenths conversions.
  localparam int PCT_DIV    = 100;
  localparam int SLEW_DIV   = 60;
  localparam int TENTHS_DIV = 10;

  // Reciprocals for division by a constant. A multiply and shift gives the
  // quotient or one less, and a single compare and add fixes it up.
  localparam int RECIP_SHIFT_24 = 24;
  localparam int RECIP_SHIFT_18 = 18;
  localparam int RECIP100       = (1 << RECIP_SHIFT_24) / PCT_DIV;
  localparam int RECIP60        = (1 << RECIP_SHIFT_24) / SLEW_DIV;
  localparam int RECIP10        = (1 << RECIP_SHIFT_18) / TENTHS_DIV;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_POS      = 4'd0,
    REG_SCALE_NEG      = 4'd1,
    REG_REVERSE        = 4'd2,
    REG_SUBTRIM_TENTHS = 4'd3,
    REG_SLEW_SPEED     = 4'd4,
    REG_MAX_PCT        = 4'd5,
    REG_MIN_PCT        = 4'd6,
    REG_SAFETY_PCT     = 4'd7
  } cfg_idx_t;

  // Bit positions in the per-update step enable mask.
  localparam int MASK_SAFETY  = 0;
  localparam int MASK_SCALE   = 1;
  localparam int MASK_REVERSE = 2;
  localparam int MASK_SUBTRIM = 3;
  localparam int MASK_SLEW    = 4;
  localparam int MASK_LIMIT   = 5;

  // Reset values of the configuration.
  localparam logic [7:0] RESET_SCALE_POS = 8'(PCT_DIV);
  localparam int         RESET_ENDPOINT_PCT = 150;
  localparam logic [15:0] RESET_LIMIT_MAG =
    16'(RESET_ENDPOINT_PCT * FULL_SCALE / PCT_DIV);

  // Configuration as the datapath consumes it, with the percent terms
  // already converted to range units.
  typedef struct packed {
    logic [7:0]         scale_pos;
    logic [7:0]         scale_neg;
    logic               reverse;
    logic               slew_on;
    logic [16:0]        slew_rate;
    logic signed [16:0] safety_range;
    logic signed [15:0] subtrim_off;
    logic [15:0]        hi_mag;
    logic [15:0]        lo_mag;
  } sol_cfg_t;

  function automatic logic [23:0] div100_u24(input logic [23:0] m);
    logic [41:0] p;
    logic [23:0] q;
    logic [23:0] r;
    p = 42'(m) * 42'(RECIP100);
    q = 24'(p >> RECIP_SHIFT_24);
    r = m - 24'(q * 24'(PCT_DIV));
    if (r >= 24'(PCT_DIV)) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  function automatic logic [23:0] div60_u24(input logic [23:0] m);
    logic [43:0] p;
    logic [23:0] q;
    logic [23:0] r;
    p = 44'(m) * 44'(RECIP60);
    q = 24'(p >> RECIP_SHIFT_24);
    r = m - 24'(q * 24'(SLEW_DIV));
    if (r >= 24'(SLEW_DIV)) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  function automatic logic [17:0] div10_u18(input logic [17:0] m);
    logic [33:0] p;
    logic [17:0] q;
    logic [17:0] r;
    p = 34'(m) * 34'(RECIP10);
    q = 18'(p >> RECIP_SHIFT_18);
    r = m - 18'(q * 18'(TENTHS_DIV));
    if (r >= 18'(TENTHS_DIV)) begin
      q = q + 18'd1;
    end
    return q;
  endfunction

  // Magnitude of a percent value in range units, truncated.
  function automatic logic [23:0] pct_to_range_mag(input logic [10:0] mag);
    return div100_u24(24'(mag) * 24'(FULL_SCALE));
  endfunction

  // First step of the slew rate: FULL_SCALE * speed / 60.
  function automatic logic [16:0] slew_rate_step1(input logic [7:0] speed);
    return 17'(div60_u24(24'(speed) * 24'(FULL_SCALE)));
  endfunction

  // Second step of the slew rate: times the update period, over 100.
  function automatic logic [16:0] slew_rate_step2(input logic [16:0] r60);
    return 17'(div100_u24(24'(r60) * 24'(UPDATE_PERIOD_MS)));
  endfunction

endpackage

[hdl/sol_cfg.sv]
module sol_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sol_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sol_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sol_pkg::sol_cfg_t               cfg_o
);

  logic               wr;
  logic [10:0]        st_in_mag;
  logic [8:0]         sf_in_mag;
  logic [23:0]        sf_range_mag;
  logic [17:0]        st_tenths;

  logic [7:0]         scale_pos_r, scale_pos_nxt;
  logic [7:0]         scale_neg_r, scale_neg_nxt;
  logic               reverse_r, reverse_nxt;
  logic               slew_on_r, slew_on_nxt;
  logic [16:0]        rate60_r, rate60_nxt;
  logic [16:0]        slew_rate_r, slew_rate_nxt;
  logic signed [16:0] safety_range_r, safety_range_nxt;
  logic [17:0]        st_mag_r, st_mag_nxt;
  logic               st_neg_r, st_neg_nxt;
  logic signed [15:0] subtrim_off_r, subtrim_off_nxt;
  logic [15:0]        hi_mag_r, hi_mag_nxt;
  logic [15:0]        lo_mag_r, lo_mag_nxt;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  assign st_in_mag    = cfg_wdata[10] ? (~cfg_wdata + 11'd1) : cfg_wdata;
  assign sf_in_mag    = cfg_wdata[8] ? (~cfg_wdata[8:0] + 9'd1) : cfg_wdata[8:0];
  assign sf_range_mag = sol_pkg::pct_to_range_mag(11'(sf_in_mag));
  assign st_tenths    = sol_pkg::div10_u18(st_mag_r);

  // Second conversion steps follow their first-step registers every cycle.
  always_comb begin
    scale_pos_nxt    = scale_pos_r;
    scale_neg_nxt    = scale_neg_r;
    reverse_nxt      = reverse_r;
    slew_on_nxt      = slew_on_r;
    rate60_nxt       = rate60_r;
    safety_range_nxt = safety_range_r;
    st_mag_nxt       = st_mag_r;
    st_neg_nxt       = st_neg_r;
    hi_mag_nxt       = hi_mag_r;
    lo_mag_nxt       = lo_mag_r;
    slew_rate_nxt    = sol_pkg::slew_rate_step2(rate60_r);
    subtrim_off_nxt  = st_neg_r ? -$signed(16'(st_tenths)) : $signed(16'(st_tenths));
    if (wr) begin
      case (sol_pkg::cfg_idx_t'(cfg_index))
        sol_pkg::REG_SCALE_POS: begin
          scale_pos_nxt = cfg_wdata[7:0];
        end
        sol_pkg::REG_SCALE_NEG: begin
          scale_neg_nxt = cfg_wdata[7:0];
        end
        sol_pkg::REG_REVERSE: begin
          reverse_nxt = cfg_wdata[0];
        end
        sol_pkg::REG_SUBTRIM_TENTHS: begin
          st_mag_nxt = 18'(sol_pkg::pct_to_range_mag(st_in_mag));
          st_neg_nxt = cfg_wdata[10];
        end
        sol_pkg::REG_SLEW_SPEED: begin
          slew_on_nxt = (cfg_wdata[7:0] != 8'd0);
          rate60_nxt  = sol_pkg::slew_rate_step1(cfg_wdata[7:0]);
        end
        sol_pkg::REG_MAX_PCT: begin
          hi_mag_nxt = 16'(sol_pkg::pct_to_range_mag(11'(cfg_wdata[7:0])));
        end
        sol_pkg::REG_MIN_PCT: begin
          lo_mag_nxt = 16'(sol_pkg::pct_to_range_mag(11'(cfg_wdata[7:0])));
        end
        sol_pkg::REG_SAFETY_PCT: begin
          safety_range_nxt = cfg_wdata[8] ? -$signed(17'(sf_range_mag))
                                          : $signed(17'(sf_range_mag));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_pos_r    <= sol_pkg::RESET_SCALE_POS;
      scale_neg_r    <= 8'd0;
      reverse_r      <= 1'b0;
      slew_on_r      <= 1'b0;
      rate60_r       <= 17'd0;
      slew_rate_r    <= 17'd0;
      safety_range_r <= 17'sd0;
      st_mag_r       <= 18'd0;
      st_neg_r       <= 1'b0;
      subtrim_off_r  <= 16'sd0;
      hi_mag_r       <= sol_pkg::RESET_LIMIT_MAG;
      lo_mag_r       <= sol_pkg::RESET_LIMIT_MAG;
    end else begin
      scale_pos_r    <= scale_pos_nxt;
      scale_neg_r    <= scale_neg_nxt;
      reverse_r      <= reverse_nxt;
      slew_on_r      <= slew_on_nxt;
      rate60_r       <= rate60_nxt;
      slew_rate_r    <= slew_rate_nxt;
      safety_range_r <= safety_range_nxt;
      st_mag_r       <= st_mag_nxt;
      st_neg_r       <= st_neg_nxt;
      subtrim_off_r  <= subtrim_off_nxt;
      hi_mag_r       <= hi_mag_nxt;
      lo_mag_r       <= lo_mag_nxt;
    end
  end

  always_comb begin
    cfg_o.scale_pos    = scale_pos_r;
    cfg_o.scale_neg    = scale_neg_r;
    cfg_o.reverse      = reverse_r;
    cfg_o.slew_on      = slew_on_r;
    cfg_o.slew_rate    = slew_rate_r;
    cfg_o.safety_range = safety_range_r;
    cfg_o.subtrim_off  = subtrim_off_r;
    cfg_o.hi_mag       = hi_mag_r;
    cfg_o.lo_mag       = lo_mag_r;
  end

endmodule

[hdl/servo_output_limiter.sv]
// Servo output limiter: conditions one servo channel per transaction. The
// mixer value plus trim (or the safety value while the safety step is enabled
// and the switch is on) goes through asymmetric scaling, reverse, subtrim, a
// slew limit against the previous output (skipped while safety is forcing the
// value) and endpoint clamping, or 16-bit saturation when limits are off;
// each step has its own bit in in_apply_mask. The block takes one transaction
// per clock cycle unless in_stall is high, and holds up to four in flight.
// A result passes through an input register, a scaling multiply register,
// a divide-by-100 / reverse / subtrim register, and the result register,
// where the slew limit and clamp are applied against the previous output.
// Because the previous output lives right at the result register,
// back-to-back transactions see each other's results with no gap.
// in_stall rises only when all four stages hold data and out_stall is high.
// Configuration writes are always taken (cfg_ready is tied high) and must
// come while no transaction is in flight; the percent terms are converted to
// range units in the write cycle and the cycle after, which is ahead of the
// stage that uses them, so a transaction may follow a write at once.
module servo_output_limiter (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_mixed_value,
  input  logic signed [14:0]              in_trim_value,
  input  logic                            in_safety_on,
  input  logic [5:0]                      in_apply_mask,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              out_servo_value,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sol_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sol_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sol_pkg::sol_cfg_t cfg;

  sol_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Pipeline flow control. Each stage takes new data when it is empty or
  // when the stage after it is taking its current contents.
  logic out_ready;
  logic s3_ready;
  logic s2_ready;
  logic s1_ready;
  logic s3_fire;

  logic               s1_valid_r;
  logic signed [15:0] s1_mixed_r;
  logic signed [14:0] s1_trim_r;
  logic               s1_safety_r;
  logic [5:0]         s1_mask_r;

  logic               s2_valid_r;
  logic signed [16:0] s2_v0_r, s2_v0_nxt;
  logic [23:0]        s2_prod_r, s2_prod_nxt;
  logic               s2_neg_r;
  logic               s2_forced_r, s2_forced_nxt;
  logic [5:0]         s2_mask_r;

  logic               s3_valid_r;
  logic signed [18:0] s3_v_r, s3_v_nxt;
  logic               s3_slew_r, s3_slew_nxt;
  logic               s3_limit_r;

  logic               out_valid_r;
  logic signed [15:0] out_value_r, out_value_nxt;
  logic signed [15:0] last_output_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s3_fire   = s3_valid_r && out_ready;
  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;

  // Stage 1 to 2: start value, safety substitution and the scaling multiply.
  logic signed [16:0] sum;
  logic signed [16:0] v0_neg;
  logic [15:0]        v0_mag;
  logic [7:0]         scale_sel;

  always_comb begin
    sum           = 17'(s1_mixed_r) + 17'(s1_trim_r);
    s2_forced_nxt = s1_mask_r[sol_pkg::MASK_SAFETY] & s1_safety_r;
    s2_v0_nxt     = s2_forced_nxt ? cfg.safety_range : sum;
    v0_neg        = -s2_v0_nxt;
    v0_mag        = s2_v0_nxt[16] ? v0_neg[15:0] : s2_v0_nxt[15:0];
    // The negative scale applies only to negative values, and only when set.
    scale_sel     = (s2_v0_nxt[16] && (cfg.scale_neg != 8'd0)) ? cfg.scale_neg
                                                              : cfg.scale_pos;
    s2_prod_nxt   = 24'(v0_mag) * 24'(scale_sel);
  end

  // Stage 2 to 3: finish the scale with a truncating divide by 100, then
  // reverse and subtrim.
  logic [16:0]        quo;
  logic signed [17:0] quo_s;
  logic signed [17:0] scaled;
  logic signed [17:0] v1;
  logic signed [17:0] v2;

  always_comb begin
    quo         = 17'(sol_pkg::div100_u24(s2_prod_r));
    quo_s       = $signed({1'b0, quo});
    scaled      = s2_neg_r ? -quo_s : quo_s;
    v1          = s2_mask_r[sol_pkg::MASK_SCALE] ? scaled : 18'(s2_v0_r);
    v2          = (s2_mask_r[sol_pkg::MASK_REVERSE] && cfg.reverse) ? -v1 : v1;
    s3_v_nxt    = 19'(v2) + (s2_mask_r[sol_pkg::MASK_SUBTRIM] ? 19'(cfg.subtrim_off)
                                                             : 19'sd0);
    // A forced safety value is never rate limited.
    s3_slew_nxt = !s2_forced_r && s2_mask_r[sol_pkg::MASK_SLEW];
  end

  // Stage 3 to result: slew against the previous output, endpoints, and
  // saturation to the 16-bit output.
  logic signed [19:0] last_ext;
  logic signed [19:0] v_ext;
  logic signed [19:0] rate_ext;
  logic signed [19:0] diff;
  logic signed [19:0] slewed;
  logic signed [19:0] hi_ext;
  logic signed [19:0] lo_ext;
  logic signed [19:0] limited;

  always_comb begin
    last_ext = 20'(last_output_r);
    v_ext    = 20'(s3_v_r);
    rate_ext = $signed({3'b000, cfg.slew_rate});
    diff     = v_ext - last_ext;
    hi_ext   = $signed({4'b0000, cfg.hi_mag});
    lo_ext   = -$signed({4'b0000, cfg.lo_mag});

    slewed = v_ext;
    if (s3_slew_r && cfg.slew_on) begin
      if (diff > rate_ext) begin
        slewed = last_ext + rate_ext;
      end else if (diff < -rate_ext) begin
        slewed = last_ext - rate_ext;
      end
    end

    limited = slewed;
    if (s3_limit_r) begin
      if (slewed > hi_ext) begin
        limited = hi_ext;
      end else if (slewed < lo_ext) begin
        limited = lo_ext;
      end
    end

    if (limited > 20'sd32767) begin
      out_value_nxt = 16'sh7fff;
    end else if (limited < -20'sd32768) begin
      out_value_nxt = 16'sh8000;
    end else begin
      out_value_nxt = limited[15:0];
    end
  end

  // Valid bits and the previous-output state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_output_r <= 16'sd0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s3_valid_r;
      end
      if (s3_fire) begin
        last_output_r <= out_value_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_mixed_r  <= in_mixed_value;
      s1_trim_r   <= in_trim_value;
      s1_safety_r <= in_safety_on;
      s1_mask_r   <= in_apply_mask;
    end
    if (s2_ready) begin
      s2_v0_r     <= s2_v0_nxt;
      s2_prod_r   <= s2_prod_nxt;
      s2_neg_r    <= s2_v0_nxt[16];
      s2_forced_r <= s2_forced_nxt;
      s2_mask_r   <= s1_mask_r;
    end
    if (s3_ready) begin
      s3_v_r     <= s3_v_nxt;
      s3_slew_r  <= s3_slew_nxt;
      s3_limit_r <= s2_mask_r[sol_pkg::MASK_LIMIT];
    end
    if (s3_fire) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_value = out_value_r;

  // The slew reference must be exactly the result just handed to the output.
  ap_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    s3_fire |=> (out_servo_value == last_output_r))
    else $error("previous-output state differs from the delivered result");

  // Input backpressure only when every stage is occupied and the output waits.
  ap_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // With limits enabled, a delivered result lies within the endpoints.
  ap_endpoints: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_fire && s3_limit_r) |=>
      (($signed(out_servo_value) <= $signed({1'b0, $past(cfg.hi_mag)})) &&
       ($signed(out_servo_value) >= -$signed({1'b0, $past(cfg.lo_mag)}))))
    else $error("limited result outside the endpoints");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Testbench for the servo output limiter. Transactions go in through the
// in_ channel and results come back through the out_ channel. Every accepted
// input transaction is run through a local copy of the conditioning chain,
// and the predicted servo value is queued. Each accepted result is then
// checked against the oldest queued value.
module tb;

  localparam int CLK_PERIOD       = 10;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int RANDOM_PHASES    = 15;
  localparam int ITEMS_PER_PHASE  = 90;
  localparam int HOLD_PHASE       = 2;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL       = 8;
  localparam int NUM_REGS         = 8;

  typedef logic [sol_pkg::CFG_IDX_W-1:0] reg_idx_t;

  // An index past the last register. Writes to it must leave everything alone.
  localparam reg_idx_t UNUSED_REG_IDX = 4'd12;

  // Step enables for the apply mask: none, each step alone, or all.
  localparam logic [5:0] STEP_NONE    = 6'd0;
  localparam logic [5:0] STEP_SAFETY  = 6'(1 << sol_pkg::MASK_SAFETY);
  localparam logic [5:0] STEP_SCALE   = 6'(1 << sol_pkg::MASK_SCALE);
  localparam logic [5:0] STEP_REVERSE = 6'(1 << sol_pkg::MASK_REVERSE);
  localparam logic [5:0] STEP_SUBTRIM = 6'(1 << sol_pkg::MASK_SUBTRIM);
  localparam logic [5:0] STEP_SLEW    = 6'(1 << sol_pkg::MASK_SLEW);
  localparam logic [5:0] STEP_LIMIT   = 6'(1 << sol_pkg::MASK_LIMIT);
  localparam logic [5:0] STEP_ALL     = 6'h3F;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [15:0]             in_mixed_value;
  logic signed [14:0]             in_trim_value;
  logic                           in_safety_on;
  logic [5:0]                     in_apply_mask;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [15:0]             out_servo_value;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [sol_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sol_pkg::CFG_DATA_W-1:0] cfg_wdata;

  servo_output_limiter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mixed_value  (in_mixed_value),
    .in_trim_value   (in_trim_value),
    .in_safety_on    (in_safety_on),
    .in_apply_mask   (in_apply_mask),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_servo_value (out_servo_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Local mirror of the configuration registers, at their register widths.
  logic [7:0]         cf_scale_pos;
  logic [7:0]         cf_scale_neg;
  logic               cf_reverse;
  logic signed [10:0] cf_subtrim;
  logic [7:0]         cf_slew_speed;
  logic [7:0]         cf_max_pct;
  logic [7:0]         cf_min_pct;
  logic signed [8:0]  cf_safety_pct;

  // Previous output of the channel, as the slew step sees it.
  logic signed [15:0] servo_last;

  // Servo values still owed by the block, oldest first.
  logic signed [15:0] servo_due[$];
  logic signed [15:0] servo_head;

  int fail_count  = 0;
  int cycle_count = 0;

  // Set by the stimulus to have the receiver hold off for a long stretch.
  bit long_hold_req = 1'b0;
  // While set, the sender offers transactions back to back.
  bit tx_burst      = 1'b0;

  // One row of the directed table: either a register write or an input
  // transaction. A row with has_want carries a value that is obvious from the
  // configuration at hand, and that value is checked in place of the
  // predicted one.
  typedef struct packed {
    logic                 is_cfg;
    reg_idx_t             idx;
    logic [10:0]          wdata;
    logic signed [15:0]   mixed;
    logic signed [14:0]   trim;
    logic                 safety;
    logic [5:0]           mask;
    logic                 has_want;
    logic signed [15:0]   want;
  } step_row_t;

  step_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Percent (or tenths) to range units, truncated toward zero.
  function automatic longint pct_range(input longint pct);
    return pct * sol_pkg::FULL_SCALE / sol_pkg::PCT_DIV;
  endfunction

  // Conditioning chain for one transaction, against the mirrored
  // configuration and the previous output. Arithmetic is done at 64 bits so
  // that nothing wraps before the final saturation.
  function automatic logic signed [15:0] predict_servo(
    input logic signed [15:0] mixed,
    input logic signed [14:0] trim,
    input logic               safety,
    input logic [5:0]         mask
  );
    longint v;
    longint prev_out;
    longint gain;
    longint tenths;
    longint speed;
    longint rate;
    longint hi;
    longint lo;
    longint forced_pct;
    bit     forced;
    v        = mixed;
    v        = v + trim;
    prev_out = servo_last;
    forced   = 1'b0;
    if (mask[sol_pkg::MASK_SAFETY] && safety) begin
      forced     = 1'b1;
      forced_pct = cf_safety_pct;
      v          = pct_range(forced_pct);
    end
    // Negative values use their own gain unless it is zero.
    if (mask[sol_pkg::MASK_SCALE]) begin
      if (v >= 0 || cf_scale_neg == 8'd0) begin
        gain = cf_scale_pos;
      end else begin
        gain = cf_scale_neg;
      end
      v = v * gain / sol_pkg::PCT_DIV;
    end
    if (mask[sol_pkg::MASK_REVERSE] && cf_reverse) begin
      v = -v;
    end
    if (mask[sol_pkg::MASK_SUBTRIM]) begin
      tenths = cf_subtrim;
      v      = v + pct_range(tenths) / sol_pkg::TENTHS_DIV;
    end
    // The slew limit never holds back a forced safety value.
    if (!forced && mask[sol_pkg::MASK_SLEW] && cf_slew_speed != 8'd0) begin
      speed = cf_slew_speed;
      rate  = sol_pkg::FULL_SCALE * speed / sol_pkg::SLEW_DIV
              * sol_pkg::UPDATE_PERIOD_MS / sol_pkg::PCT_DIV;
      if (v - prev_out > rate) begin
        v = prev_out + rate;
      end else if (v - prev_out < -rate) begin
        v = prev_out - rate;
      end
    end
    if (mask[sol_pkg::MASK_LIMIT]) begin
      hi = cf_max_pct;
      hi = pct_range(hi);
      lo = cf_min_pct;
      lo = pct_range(-lo);
      if (v > hi) begin
        v = hi;
      end else if (v < lo) begin
        v = lo;
      end
    end
    // The output register is 16 bits wide, endpoints or not.
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  // A write keeps only the bits that the register holds.
  function automatic void mirror_write(input reg_idx_t idx,
                                       input logic [10:0] data);
    case (idx)
      sol_pkg::REG_SCALE_POS:      cf_scale_pos  = data[7:0];
      sol_pkg::REG_SCALE_NEG:      cf_scale_neg  = data[7:0];
      sol_pkg::REG_REVERSE:        cf_reverse    = data[0];
      sol_pkg::REG_SUBTRIM_TENTHS: cf_subtrim    = data;
      sol_pkg::REG_SLEW_SPEED:     cf_slew_speed = data[7:0];
      sol_pkg::REG_MAX_PCT:        cf_max_pct    = data[7:0];
      sol_pkg::REG_MIN_PCT:        cf_min_pct    = data[7:0];
      sol_pkg::REG_SAFETY_PCT:     cf_safety_pct = data[8:0];
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic signed [15:0] mixed,
                                   input logic signed [14:0] trim,
                                   input logic safety, input logic [5:0] mask,
                                   input logic has_want,
                                   input logic signed [15:0] want);
    step_row_t row;
    row          = '0;
    row.mixed    = mixed;
    row.trim     = trim;
    row.safety   = safety;
    row.mask     = mask;
    row.has_want = has_want;
    row.want     = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input reg_idx_t idx, input int value);
    step_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = 11'(value);
    directed_rows.push_back(row);
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // Register values lean toward the ends of each range. A quarter of the
  // writes use the whole data width, which also reaches out-of-range values.
  function automatic logic [10:0] pick_reg_value(input reg_idx_t idx);
    int r;
    r = $urandom_range(0, 3);
    if (r == 3) begin
      return 11'($urandom);
    end
    case (idx)
      sol_pkg::REG_REVERSE:
        return 11'($urandom_range(0, 1));
      sol_pkg::REG_SUBTRIM_TENTHS:
        return (r == 0) ? 11'(-1000) : (r == 1) ? 11'(1000)
                        : 11'(int'($urandom_range(0, 2000)) - 1000);
      sol_pkg::REG_MAX_PCT, sol_pkg::REG_MIN_PCT:
        return (r == 0) ? 11'(0) : (r == 1) ? 11'(250) : 11'($urandom_range(0, 250));
      sol_pkg::REG_SAFETY_PCT:
        return (r == 0) ? 11'(-150) : (r == 1) ? 11'(150)
                        : 11'(int'($urandom_range(0, 300)) - 150);
      default:
        return (r == 0) ? 11'(0) : (r == 1) ? 11'(255) : 11'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one transaction and waits until the block takes it. Valid stays
  // high afterwards; the next call, idle_input or drain_results decides it
  // at the following falling edge.
  task automatic drive_item(input logic signed [15:0] mixed,
                            input logic signed [14:0] trim,
                            input logic safety, input logic [5:0] mask,
                            input logic has_want,
                            input logic signed [15:0] want);
    logic signed [15:0] servo_pred;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_mixed_value <= mixed;
    in_trim_value  <= trim;
    in_safety_on   <= safety;
    in_apply_mask  <= mask;
    do @(posedge clk); while (in_stall);
    servo_pred = predict_servo(mixed, trim, safety, mask);
    servo_last = servo_pred;
    servo_due.push_back(has_want ? want : servo_pred);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (servo_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [10:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    mirror_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: alternates between free-running stretches and stalls. A long
  // hold-off, when requested, is counted here so that the sender can keep
  // offering transactions meanwhile and fill the pipeline.
  initial begin
    int  run_left;
    bit  stalled;
    run_left  = 0;
    stalled   = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
        stalled  = 1'b0;
        run_left = $urandom_range(1, 20);
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stalled = !stalled;
        out_stall <= stalled;
        if (stalled) begin
          run_left = pick_idle_len() - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          run_left = $urandom_range(100, 300);
        end else begin
          run_left = $urandom_range(0, 30);
        end
      end
    end
  end

  // Result checker: every accepted result takes the oldest owed value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (servo_due.size() == 0) begin
        $error("servo_value: no transaction pending, actual %0d", out_servo_value);
        fail_count++;
      end else begin
        servo_head = servo_due.pop_front();
        if (out_servo_value !== servo_head) begin
          $error("servo_value: expected %0d, actual %0d", servo_head, out_servo_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("servo_output_limiter: mismatch");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] mixed;
    logic signed [14:0] trim;
    logic               safety;
    logic [5:0]         mask;
    int                 kind;
    step_row_t          row;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mixed_value = '0;
    in_trim_value  = '0;
    in_safety_on   = 1'b0;
    in_apply_mask  = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;

    cf_scale_pos  = sol_pkg::RESET_SCALE_POS;
    cf_scale_neg  = 8'd0;
    cf_reverse    = 1'b0;
    cf_subtrim    = '0;
    cf_slew_speed = 8'd0;
    cf_max_pct    = 8'(sol_pkg::RESET_ENDPOINT_PCT);
    cf_min_pct    = 8'(sol_pkg::RESET_ENDPOINT_PCT);
    cf_safety_pct = '0;
    servo_last    = '0;

    // With the reset configuration the first rows can be worked out by hand:
    // unit gain, no reverse, no subtrim, no slew, endpoints at 150 percent.
    add_item(16'sd0, 15'sd0, 1'b0, STEP_NONE, 1'b1, 16'sd0);
    add_item(16'sd32767, 15'sd10000, 1'b0, STEP_NONE, 1'b1, 16'sd32767);
    add_item(-16'sd32768, -15'sd10000, 1'b0, STEP_NONE, 1'b1, -16'sd32768);
    add_item(16'sd0, 15'sd16383, 1'b0, STEP_NONE, 1'b1, 16'sd16383);
    add_item(16'sd0, -15'sd16384, 1'b0, STEP_NONE, 1'b1, -16'sd16384);
    add_item(16'sd32767, 15'sd0, 1'b0, STEP_LIMIT, 1'b1, 16'sd15000);
    add_item(-16'sd32768, 15'sd0, 1'b0, STEP_LIMIT, 1'b1, -16'sd15000);
    // The switch alone does nothing; only with the safety step does it force.
    add_item(16'sd1234, 15'sd0, 1'b1, STEP_NONE, 1'b1, 16'sd1234);
    add_item(16'sd1234, 15'sd0, 1'b1, STEP_SAFETY, 1'b1, 16'sd0);
    add_item(16'sd5000, -15'sd1000, 1'b0, STEP_ALL, 1'b1, 16'sd4000);

    // Asymmetric gain, reverse, full positive subtrim, forced value at the
    // negative end, widest upper endpoint and a zero lower one.
    add_cfg(sol_pkg::REG_SCALE_POS, 255);
    add_cfg(sol_pkg::REG_SCALE_NEG, 50);
    add_cfg(sol_pkg::REG_REVERSE, 1);
    add_cfg(sol_pkg::REG_SUBTRIM_TENTHS, 1000);
    add_cfg(sol_pkg::REG_SAFETY_PCT, -150);
    add_cfg(sol_pkg::REG_MAX_PCT, 250);
    add_cfg(sol_pkg::REG_MIN_PCT, 0);
    add_cfg(UNUSED_REG_IDX, 2047);
    add_item(16'sd20000, 15'sd0, 1'b0, STEP_SCALE, 1'b1, 16'sd32767);
    add_item(-16'sd20000, 15'sd0, 1'b0, STEP_SCALE, 1'b0, 16'sd0);
    add_item(16'sd100, 15'sd0, 1'b0, STEP_REVERSE, 1'b0, 16'sd0);
    add_item(16'sd0, 15'sd0, 1'b0, STEP_SUBTRIM, 1'b0, 16'sd0);
    add_item(16'sd0, 15'sd0, 1'b1, STEP_SAFETY | STEP_LIMIT, 1'b0, 16'sd0);
    add_item(16'sd32767, 15'sd16383, 1'b0, STEP_LIMIT, 1'b0, 16'sd0);

    // Slowest slew: the forced value in the middle must jump past the limit.
    add_cfg(sol_pkg::REG_SLEW_SPEED, 1);
    add_item(16'sd30000, 15'sd0, 1'b0, STEP_SLEW, 1'b0, 16'sd0);
    add_item(16'sd30000, 15'sd0, 1'b1, STEP_SLEW | STEP_SAFETY, 1'b0, 16'sd0);
    add_item(-16'sd30000, 15'sd0, 1'b0, STEP_SLEW, 1'b0, 16'sd0);
    add_cfg(sol_pkg::REG_SLEW_SPEED, 255);
    add_cfg(sol_pkg::REG_SUBTRIM_TENTHS, -1000);
    add_item(-16'sd32768, -15'sd16384, 1'b0, STEP_ALL, 1'b0, 16'sd0);
    add_item(16'sd32767, 15'sd16383, 1'b0, STEP_ALL, 1'b0, 16'sd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register writes only go in once the pipeline is empty.
    for (int k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.is_cfg) begin
        drain_results();
        cfg_write(row.idx, row.wdata);
      end else begin
        drive_item(row.mixed, row.trim, row.safety, row.mask, row.has_want, row.want);
        if ($urandom_range(0, 1) == 0) begin
          idle_input(pick_idle_len());
        end
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      for (int i = 0; i < NUM_REGS; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          cfg_write(reg_idx_t'(i), pick_reg_value(reg_idx_t'(i)));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(reg_idx_t'($urandom_range(NUM_REGS, 15)), 11'($urandom));
      end

      // One phase runs against a long receiver hold-off with the sender
      // never pausing, so the pipeline fills and in_stall has to rise.
      tx_burst = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) begin
        long_hold_req = 1'b1;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          // Plausible stick travel with modest trim, so that slew and
          // endpoints see values that track from one update to the next.
          mixed  = 16'(int'($urandom_range(0, 30000)) - 15000);
          trim   = 15'(int'($urandom_range(0, 2000)) - 1000);
          safety = ($urandom_range(0, 3) == 0);
          mask   = 6'($urandom);
        end else begin
          mixed  = 16'($urandom);
          trim   = 15'($urandom);
          safety = 1'($urandom);
          mask   = 6'($urandom);
        end
        drive_item(mixed, trim, safety, mask, 1'b0, 16'sd0);
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end else if (!tx_burst && $urandom_range(0, 1) == 0) begin
          idle_input(pick_idle_len());
        end
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("servo_output_limiter: match");
    end else begin
      $display("servo_output_limiter: mismatch");
    end
    $finish;
  end

endmodule
